[hdl/assert_macros.svh]
// Assertion macros shared by the downscaler RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AWD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AWD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/awd_pkg.sv]
// Shared types and constants of the area-weighted downscaler.
// No dependencies; imported by awd_norm and the top level.
package awd_pkg;

  localparam int MAX_TW_DEF = 2048;
  localparam int STRIP_ROWS = 8;
  localparam int STORE_ROWS = 2 * STRIP_ROWS;
  localparam int FRAC       = 14;
  localparam int COL_W      = 14;
  localparam int TX_W       = COL_W + FRAC;
  localparam int CFG_W      = 15;
  localparam int ACC_W      = 32;
  localparam int W_W        = FRAC + 1;
  localparam int SRC_MAX    = 16384;

  typedef struct packed {
    logic [ACC_W-1:0] r;
    logic [ACC_W-1:0] g;
    logic [ACC_W-1:0] b;
    logic [ACC_W-1:0] w;
  } acc_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb8_t;

  typedef enum logic [1:0] {
    KIND_TAKEN = 2'd0,
    KIND_READY = 2'd1,
    KIND_STRIP = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CFG_TARGET_WIDTH  = 3'd0,
    CFG_SOURCE_WIDTH  = 3'd1,
    CFG_SOURCE_HEIGHT = 3'd2,
    CFG_X_SCALE       = 3'd3,
    CFG_Y_SCALE       = 3'd4
  } cfg_idx_t;

endpackage

[hdl/awd_norm.sv]
// Three-lane restoring divider: colour sums over weight, clipped to 255.
// Depends on awd_pkg; one quotient bit per cycle.
module awd_norm import awd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  acc_t  acc,
  output logic  done,
  output rgb8_t q
);

  logic              busy_r, done_r, zero_r;
  logic [3:0]        cnt_r;
  logic [ACC_W-1:0]  rem_r [3];
  logic [ACC_W+7:0]  dsh_r;
  logic [7:0]        qb_r  [3];
  logic [2:0]        sat_r;
  logic [2:0]        ge;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ge[i] = {8'b0, rem_r[i]} >= dsh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        zero_r   <= (acc.w == '0);
        cnt_r    <= 4'd8;
        rem_r[0] <= acc.r;
        rem_r[1] <= acc.g;
        rem_r[2] <= acc.b;
        dsh_r    <= {acc.w, 8'b0};
        sat_r    <= '0;
        for (int i = 0; i < 3; i++) qb_r[i] <= '0;
      end else if (busy_r) begin
        if (zero_r) begin
          for (int i = 0; i < 3; i++) begin
            sat_r[i] <= (rem_r[i] > ACC_W'(255));
            qb_r[i]  <= rem_r[i][7:0];
          end
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (cnt_r == 4'd8) begin
              sat_r[i] <= ge[i];
            end else begin
              if (ge[i]) rem_r[i] <= rem_r[i] - dsh_r[ACC_W-1:0];
              qb_r[i] <= {qb_r[i][6:0], ge[i]};
            end
          end
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r - 4'd1;
          if (cnt_r == 4'd0) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  assign done = done_r;
  assign q.r  = sat_r[0] ? 8'hFF : qb_r[0];
  assign q.g  = sat_r[1] ? 8'hFF : qb_r[1];
  assign q.b  = sat_r[2] ? 8'hFF : qb_r[2];

endmodule

[hdl/area_weighted_image_downscaler.sv]
// Area-weighted downscaler: bilinear splat into a 16-row accumulator store.
// Accumulate: a position step, then weight, product and update steps per corner.
// Drain: a store read, then the restoring divider gives the result.
// End of strip: store row 8 copied to row 0, rows 1 to 15 cleared; end of frame and
// after reset: all 16 rows cleared, input held off meanwhile.
// Reset is synchronous, active low; configuration writes are taken at all times.
`include "assert_macros.svh"
module area_weighted_image_downscaler import awd_pkg::*; #(
  parameter int MAX_TARGET_WIDTH = MAX_TW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_write_en,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_operation,
  input  logic [7:0]       in_red_in,
  input  logic [7:0]       in_green_in,
  input  logic [7:0]       in_blue_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic             out_last_in_strip,
  output logic             out_saturated
);

  localparam int DEPTH  = STORE_ROWS * MAX_TARGET_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CCOL_W = $clog2(MAX_TARGET_WIDTH);
  localparam logic [ADDR_W-1:0] MTW_A   = ADDR_W'(MAX_TARGET_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] OVF_A   = ADDR_W'(STRIP_ROWS * MAX_TARGET_WIDTH);
  localparam logic [CCOL_W-1:0] CLAST   = CCOL_W'(MAX_TARGET_WIDTH - 1);
  localparam logic [COL_W-1:0]  MTW_C   = COL_W'(MAX_TARGET_WIDTH);
  localparam logic [W_W-1:0]    ONE_Q   = W_W'(1 << FRAC);
  localparam logic [CFG_W-1:0]  SMAX    = CFG_W'(SRC_MAX);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_POS, S_CW, S_CP, S_CU, S_AFIN,
    S_DRD, S_DDIV, S_OUT, S_CPRD, S_CPWR
  } state_t;

  typedef enum logic [1:0] {P_IDLE, P_COPY, P_CLRALL} post_t;

  // configuration
  logic [11:0]      tw_r;
  logic [CFG_W-1:0] sw_r, sh_r, xs_r, ys_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r <= 12'd1;
      sw_r <= CFG_W'(1);
      sh_r <= CFG_W'(1);
      xs_r <= SMAX;
      ys_r <= SMAX;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_TARGET_WIDTH:  tw_r <= cfg_data[11:0];
        CFG_SOURCE_WIDTH:  sw_r <= cfg_data;
        CFG_SOURCE_HEIGHT: sh_r <= cfg_data;
        CFG_X_SCALE:       xs_r <= cfg_data;
        CFG_Y_SCALE:       ys_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [COL_W-1:0] tw_eff;
  logic [CFG_W-1:0] sw_eff, sh_eff, xs_eff, ys_eff;

  assign tw_eff = (tw_r == '0) ? COL_W'(1) :
                  ((COL_W'(tw_r) > MTW_C) ? MTW_C : COL_W'(tw_r));
  assign sw_eff = (sw_r == '0) ? CFG_W'(1) : ((sw_r > SMAX) ? SMAX : sw_r);
  assign sh_eff = (sh_r == '0) ? CFG_W'(1) : ((sh_r > SMAX) ? SMAX : sh_r);
  assign xs_eff = (xs_r > SMAX) ? SMAX : xs_r;
  assign ys_eff = (ys_r > SMAX) ? SMAX : ys_r;

  // state
  state_t             state_r;
  post_t              post_r;
  logic [COL_W-1:0]   col_r, row_r, base_r;
  logic               pend_r;
  logic [14:0]        dpos_r;
  logic [7:0]         ri_r, gi_r, bi_r;
  logic [TX_W-1:0]    tx_r, ty_r;
  logic [1:0]         corner_r;
  logic               sat_acc_r, ok_r;
  logic [W_W-1:0]     w_r;
  logic [ADDR_W-1:0]  addr_r, clr_cnt_r;
  logic [CCOL_W-1:0]  cp_col_r;
  logic [W_W+7:0]     pr_r, pg_r, pb_r;
  logic               dlast_r, inb_r;
  kind_t              res_kind_r;
  rgb8_t              res_rgb_r;
  logic               res_last_r, res_sat_r;
  logic               out_valid_r, out_last_r, out_sat_r;
  kind_t              out_kind_r;
  rgb8_t              out_rgb_r;

  // store
  acc_t               mem [DEPTH];
  acc_t               rd_q, mem_wdata;
  logic               mem_re, mem_we;
  logic [ADDR_W-1:0]  mem_raddr, mem_waddr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  // position
  logic [TX_W:0]      tx_full, ty_full;
  assign tx_full = (TX_W+1)'(col_r) * (TX_W+1)'(xs_eff);
  assign ty_full = (TX_W+1)'(row_r) * (TX_W+1)'(ys_eff);

  logic [COL_W-1:0]   txi, tyi, diff;
  logic [W_W-1:0]     fx1, fy1, fxs, fys;
  logic [2*W_W-1:0]   wprod;
  logic [COL_W:0]     cc, lr;
  logic               cw_ok;
  logic [ADDR_W-1:0]  cw_addr;

  always_comb begin
    txi     = tx_r[TX_W-1:FRAC];
    tyi     = ty_r[TX_W-1:FRAC];
    fx1     = {1'b0, tx_r[FRAC-1:0]};
    fy1     = {1'b0, ty_r[FRAC-1:0]};
    fxs     = corner_r[0] ? fx1 : ONE_Q - fx1;
    fys     = corner_r[1] ? fy1 : ONE_Q - fy1;
    wprod   = (2*W_W)'(fxs) * (2*W_W)'(fys);
    cc      = {1'b0, txi} + (COL_W+1)'(corner_r[0]);
    diff    = tyi - base_r;
    lr      = {1'b0, diff} + (COL_W+1)'(corner_r[1]);
    cw_ok   = (tyi >= base_r) && (cc < {1'b0, tw_eff}) &&
              (lr < (COL_W+1)'(STORE_ROWS));
    cw_addr = ADDR_W'(lr[3:0]) * MTW_A + ADDR_W'(cc);
  end

  // saturating update
  logic [ACC_W:0]     sum_r, sum_g, sum_b, sum_w;
  acc_t               upd;
  logic               upd_sat;

  always_comb begin
    sum_r   = {1'b0, rd_q.r} + (ACC_W+1)'(pr_r);
    sum_g   = {1'b0, rd_q.g} + (ACC_W+1)'(pg_r);
    sum_b   = {1'b0, rd_q.b} + (ACC_W+1)'(pb_r);
    sum_w   = {1'b0, rd_q.w} + (ACC_W+1)'(w_r);
    upd.r   = sum_r[ACC_W] ? '1 : sum_r[ACC_W-1:0];
    upd.g   = sum_g[ACC_W] ? '1 : sum_g[ACC_W-1:0];
    upd.b   = sum_b[ACC_W] ? '1 : sum_b[ACC_W-1:0];
    upd.w   = sum_w[ACC_W] ? '1 : sum_w[ACC_W-1:0];
    upd_sat = sum_r[ACC_W] | sum_g[ACC_W] | sum_b[ACC_W] | sum_w[ACC_W];
  end

  // end of row
  logic last_col, last_row, strip_rdy;
  assign last_col  = ({1'b0, col_r} + 15'd1) >= sw_eff;
  assign last_row  = ({1'b0, row_r} + 15'd1) >= sh_eff;
  assign strip_rdy = last_row ||
                     ({1'b0, tyi} >= ({1'b0, base_r} + 15'(STRIP_ROWS)));

  // drain addressing
  logic [11:0]       dcol;
  logic [2:0]        drow;
  logic [COL_W:0]    tw_p15;
  logic [17:0]       total;
  logic              dlast, dinb;
  logic [ADDR_W-1:0] dr_addr;

  always_comb begin
    dcol    = {dpos_r[14:7], dpos_r[3:0]};
    drow    = dpos_r[6:4];
    tw_p15  = {1'b0, tw_eff} + (COL_W+1)'(15);
    total   = {tw_p15[COL_W:4], 7'b0};
    dlast   = (18'(dpos_r) + 18'd1) >= total;
    dinb    = COL_W'(dcol) < tw_eff;
    dr_addr = ADDR_W'(drow) * MTW_A + ADDR_W'(dcol);
  end

  logic  accept, norm_start, norm_done;
  rgb8_t norm_q;

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign norm_start = (state_r == S_DRD);

  awd_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .acc   (rd_q),
    .done  (norm_done),
    .q     (norm_q)
  );

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
      end
      S_IDLE: begin
        mem_re    = accept && in_operation && pend_r;
        mem_raddr = dr_addr;
      end
      S_CW: begin
        mem_re    = 1'b1;
        mem_raddr = cw_addr;
      end
      S_CU: begin
        mem_we    = ok_r;
        mem_waddr = addr_r;
        mem_wdata = upd;
      end
      S_CPRD: begin
        mem_re    = 1'b1;
        mem_raddr = OVF_A + ADDR_W'(cp_col_r);
      end
      S_CPWR: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(cp_col_r);
        mem_wdata = rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      post_r      <= P_IDLE;
      clr_cnt_r   <= '0;
      col_r       <= '0;
      row_r       <= '0;
      base_r      <= '0;
      pend_r      <= 1'b0;
      dpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
          if (clr_cnt_r == LAST_A) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            post_r     <= P_IDLE;
            res_rgb_r  <= '0;
            res_last_r <= 1'b0;
            res_sat_r  <= 1'b0;
            if (!in_operation) begin
              ri_r      <= in_red_in;
              gi_r      <= in_green_in;
              bi_r      <= in_blue_in;
              res_kind_r <= KIND_READY;
              if (pend_r) begin
                state_r <= S_OUT;
              end else begin
                corner_r  <= '0;
                sat_acc_r <= 1'b0;
                state_r   <= S_POS;
              end
            end else begin
              res_kind_r <= KIND_STRIP;
              dlast_r    <= dlast;
              inb_r      <= dinb;
              state_r    <= pend_r ? S_DRD : S_OUT;
            end
          end
        end
        S_POS: begin
          tx_r    <= tx_full[TX_W-1:0];
          ty_r    <= ty_full[TX_W-1:0];
          state_r <= S_CW;
        end
        S_CW: begin
          w_r     <= wprod[2*W_W-2:FRAC];
          ok_r    <= cw_ok;
          addr_r  <= cw_addr;
          state_r <= S_CP;
        end
        S_CP: begin
          pr_r    <= (W_W+8)'(w_r) * (W_W+8)'(ri_r);
          pg_r    <= (W_W+8)'(w_r) * (W_W+8)'(gi_r);
          pb_r    <= (W_W+8)'(w_r) * (W_W+8)'(bi_r);
          state_r <= S_CU;
        end
        S_CU: begin
          if (ok_r) sat_acc_r <= sat_acc_r | upd_sat;
          corner_r <= corner_r + 2'd1;
          state_r  <= (corner_r == 2'd3) ? S_AFIN : S_CW;
        end
        S_AFIN: begin
          res_kind_r <= KIND_TAKEN;
          res_sat_r  <= sat_acc_r;
          if (last_col) begin
            col_r <= '0;
            row_r <= last_row ? '0 : row_r + COL_W'(1);
            if (strip_rdy) begin
              pend_r     <= 1'b1;
              res_kind_r <= KIND_READY;
            end
          end else begin
            col_r <= col_r + COL_W'(1);
          end
          state_r <= S_OUT;
        end
        S_DRD: state_r <= S_DDIV;
        S_DDIV: begin
          if (norm_done) begin
            res_rgb_r  <= inb_r ? norm_q : '0;
            res_last_r <= dlast_r;
            if (dlast_r) begin
              pend_r <= 1'b0;
              dpos_r <= '0;
              if (row_r == '0) begin
                post_r <= P_CLRALL;
                base_r <= '0;
              end else begin
                post_r <= P_COPY;
                base_r <= base_r + COL_W'(STRIP_ROWS);
              end
            end else begin
              dpos_r <= dpos_r + 15'd1;
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= res_kind_r;
            out_rgb_r   <= res_rgb_r;
            out_last_r  <= res_last_r;
            out_sat_r   <= res_sat_r;
            unique case (post_r)
              P_COPY: begin
                cp_col_r <= '0;
                state_r  <= S_CPRD;
              end
              P_CLRALL: begin
                clr_cnt_r <= '0;
                state_r   <= S_CLEAR;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_CPRD: state_r <= S_CPWR;
        S_CPWR: begin
          cp_col_r <= cp_col_r + CCOL_W'(1);
          if (cp_col_r == CLAST) begin
            clr_cnt_r <= MTW_A;
            state_r   <= S_CLEAR;
          end else begin
            state_r <= S_CPRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_red_out       = out_rgb_r.r;
  assign out_green_out     = out_rgb_r.g;
  assign out_blue_out      = out_rgb_r.b;
  assign out_last_in_strip = out_last_r;
  assign out_saturated     = out_sat_r;

  `AWD_ASSERT_IMP(a_idle_no_write, clk, rst_n, in_ready, !mem_we)
  `AWD_ASSERT_IMP(a_last_is_drain, clk, rst_n, out_valid_r && out_last_r,
                  out_kind_r == KIND_STRIP)
  `AWD_ASSERT_IMP(a_sat_not_drain, clk, rst_n, out_valid_r && out_sat_r,
                  out_kind_r != KIND_STRIP)
  `AWD_ASSERT_NXT(a_strip_end_sweep, clk, rst_n,
                  state_r == S_OUT && post_r != P_IDLE && (!out_valid_r || out_ready),
                  !in_ready && !pend_r)

endmodule

[verif/testbench.sv]
// Self-checking testbench for area_weighted_image_downscaler.
// Drives source pixels and strip drains through valid/ready, mirrors the
// accumulator store in a local splat model and checks every result; needs awd_pkg.
`timescale 1ns / 1ps
module testbench;
  import awd_pkg::*;

  localparam int TW_MAX     = 2048;
  localparam int DEPTH      = STORE_ROWS * TW_MAX;
  localparam int ONE_Q      = 1 << FRAC;
  localparam int IDLE_LIMIT = 150000;
  localparam int ITEM_GOAL  = 1950;

  typedef enum bit {OP_ACCUMULATE = 1'b0, OP_DRAIN = 1'b1} op_t;

  typedef struct {
    op_t        op;
    logic [7:0] r, g, b;
  } pixel_item_t;

  typedef struct {
    kind_t kind;
    rgb8_t rgb;
    bit    last;
    bit    sat;
  } downscale_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_write_en = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_operation = 1'b0;
  logic [7:0]       in_red_in = '0, in_green_in = '0, in_blue_in = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       out_result_kind;
  logic [7:0]       out_red_out, out_green_out, out_blue_out;
  logic             out_last_in_strip, out_saturated;

  area_weighted_image_downscaler dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // local copy of configuration and datapath state
  logic [11:0] tw_reg = 12'd1;
  logic [14:0] sw_reg = 15'd1, sh_reg = 15'd1, xs_reg = 15'd16384, ys_reg = 15'd16384;
  bit [31:0] red_sum[DEPTH], green_sum[DEPTH], blue_sum[DEPTH], weight_sum[DEPTH];
  int unsigned src_col, src_row, base_row, drain_pos;
  bit strip_ready;

  pixel_item_t       pixel_q[$];
  downscale_result_t result_q[$];
  int errors, n_items, idle_cycles;
  bit quiet_in, quiet_out;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned eff_tw();
    return clampu(tw_reg, 1, TW_MAX);
  endfunction

  function automatic bit add_sat(ref bit [31:0] acc, input bit [31:0] v);
    bit [32:0] s;
    s = {1'b0, acc} + v;
    acc = s[32] ? 32'hFFFF_FFFF : s[31:0];
    return s[32];
  endfunction

  function automatic logic [7:0] normalize(bit [31:0] sum, bit [31:0] w);
    bit [31:0] v;
    v = (w != 0) ? sum / w : sum;
    return v > 255 ? 8'd255 : v[7:0];
  endfunction

  task automatic close_strip();
    if (src_row == 0) begin
      for (int i = 0; i < DEPTH; i++) begin
        red_sum[i] = 0; green_sum[i] = 0; blue_sum[i] = 0; weight_sum[i] = 0;
      end
      base_row = 0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i < TW_MAX) begin
          red_sum[i] = red_sum[i + STRIP_ROWS*TW_MAX];
          green_sum[i] = green_sum[i + STRIP_ROWS*TW_MAX];
          blue_sum[i] = blue_sum[i + STRIP_ROWS*TW_MAX];
          weight_sum[i] = weight_sum[i + STRIP_ROWS*TW_MAX];
        end else begin
          red_sum[i] = 0; green_sum[i] = 0; blue_sum[i] = 0; weight_sum[i] = 0;
        end
      end
      base_row = (base_row + STRIP_ROWS) & 14'h3FFF;
    end
    strip_ready = 0;
    drain_pos = 0;
  endtask

  task automatic predict_downscale(input pixel_item_t it, output downscale_result_t e);
    int unsigned tw, sw, sh, xs, ys, tx, ty, txi, tyi, c, lr, idx, p, total, col, row;
    int unsigned fx[2], fy[2];
    bit [31:0] w;
    bit sat, last_row;
    tw = eff_tw();
    e = '{KIND_TAKEN, '0, 1'b0, 1'b0};
    if (it.op == OP_ACCUMULATE) begin
      if (strip_ready) begin
        e.kind = KIND_READY;
        return;
      end
      sw = clampu(sw_reg, 1, SRC_MAX);
      sh = clampu(sh_reg, 1, SRC_MAX);
      xs = xs_reg > ONE_Q ? ONE_Q : xs_reg;
      ys = ys_reg > ONE_Q ? ONE_Q : ys_reg;
      tx = src_col * xs;
      ty = src_row * ys;
      fx[1] = tx & (ONE_Q - 1); fx[0] = ONE_Q - fx[1]; txi = tx >> FRAC;
      fy[1] = ty & (ONE_Q - 1); fy[0] = ONE_Q - fy[1]; tyi = ty >> FRAC;
      sat = 0;
      for (int dy = 0; dy < 2; dy++)
        for (int dx = 0; dx < 2; dx++) begin
          c = txi + dx;
          if (tyi < base_row || c >= tw) continue;
          lr = tyi - base_row + dy;
          if (lr >= STORE_ROWS) continue;
          w = 32'((64'(fx[dx]) * fy[dy]) >> FRAC);
          idx = lr * TW_MAX + c;
          sat |= add_sat(red_sum[idx], w * it.r);
          sat |= add_sat(green_sum[idx], w * it.g);
          sat |= add_sat(blue_sum[idx], w * it.b);
          sat |= add_sat(weight_sum[idx], w);
        end
      if (src_col + 1 >= sw) begin
        last_row = (src_row + 1 >= sh);
        src_col = 0;
        if (last_row || tyi >= base_row + STRIP_ROWS) begin
          strip_ready = 1;
          e.kind = KIND_READY;
        end
        src_row = last_row ? 0 : ((src_row + 1) & 14'h3FFF);
      end else begin
        src_col = (src_col + 1) & 14'h3FFF;
      end
      e.sat = sat;
      return;
    end
    e.kind = KIND_STRIP;
    if (!strip_ready) return;
    total = ((tw + 15) >> 4) * 128;
    p = drain_pos;
    col = (p >> 7) * 16 + (p & 15);
    row = (p >> 4) & 7;
    if (col < tw) begin
      idx = row * TW_MAX + col;
      e.rgb.r = normalize(red_sum[idx], weight_sum[idx]);
      e.rgb.g = normalize(green_sum[idx], weight_sum[idx]);
      e.rgb.b = normalize(blue_sum[idx], weight_sum[idx]);
    end
    e.last = (p + 1 >= total);
    if (e.last) close_strip();
    else drain_pos = (p + 1) & 15'h7FFF;
  endtask

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  int in_gap;
  always @(posedge clk) begin
    downscale_result_t e;
    pixel_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        it = '{op_t'(in_operation), in_red_in, in_green_in, in_blue_in};
        predict_downscale(it, e);
        result_q.push_back(e);
      end
      if (!(in_valid && !in_ready)) begin
        if ($urandom_range(0, 149) == 0) quiet_in = ~quiet_in;
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          it = pixel_q.pop_front();
          in_operation <= it.op;
          in_red_in <= it.r;
          in_green_in <= it.g;
          in_blue_in <= it.b;
          in_valid <= 1'b1;
          in_gap <= pick_gap(quiet_in);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_gap;
  always @(posedge clk) begin
    downscale_result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report("unexpected transfer kind", out_result_kind, -1);
        end else begin
          e = result_q.pop_front();
          if (out_result_kind !== e.kind) report("result_kind", out_result_kind, e.kind);
          if (out_red_out !== e.rgb.r) report("red_out", out_red_out, e.rgb.r);
          if (out_green_out !== e.rgb.g) report("green_out", out_green_out, e.rgb.g);
          if (out_blue_out !== e.rgb.b) report("blue_out", out_blue_out, e.rgb.b);
          if (out_last_in_strip !== e.last)
            report("last_in_strip", out_last_in_strip, e.last);
          if (out_saturated !== e.sat) report("saturated", out_saturated, e.sat);
        end
      end
      if ($urandom_range(0, 149) == 0) quiet_out = ~quiet_out;
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap <= pick_gap(quiet_out);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned value);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    case (idx)
      CFG_TARGET_WIDTH:  tw_reg = value[11:0];
      CFG_SOURCE_WIDTH:  sw_reg = value[14:0];
      CFG_SOURCE_HEIGHT: sh_reg = value[14:0];
      CFG_X_SCALE:       xs_reg = value[14:0];
      CFG_Y_SCALE:       ys_reg = value[14:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  function automatic logic [7:0] rand_chan();
    int r;
    r = $urandom_range(0, 7);
    return r == 0 ? 8'd0 : (r == 1 ? 8'd255 : 8'($urandom_range(0, 255)));
  endfunction

  task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_q.push_back('{OP_ACCUMULATE, r, g, b});
    n_items++;
  endtask

  task automatic push_drain();
    pixel_q.push_back('{OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom)});
    n_items++;
  endtask

  task automatic flush_strip();
    repeat (((eff_tw() + 15) >> 4) * 128) push_drain();
    wait_idle();
    while (strip_ready) begin
      push_drain();
      wait_idle();
    end
  endtask

  task automatic run_rows(int rows, bit noisy);
    int unsigned sw;
    sw = clampu(sw_reg, 1, SRC_MAX);
    repeat (rows) begin
      repeat (sw) push_pixel(rand_chan(), rand_chan(), rand_chan());
      wait_idle();
      if (strip_ready) begin
        if (noisy) pixel_q.push_back('{OP_ACCUMULATE, 8'hFF, 8'h00, 8'hA5});
        flush_strip();
      end
    end
  endtask

  function automatic int unsigned rand_scale();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 16384;
    if (r == 3) return $urandom_range(16385, 32767);
    return $urandom_range(2048, 16384);
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // drain with no strip ready, then extremes of the pixel fields
    write_reg(CFG_TARGET_WIDTH, 0);
    write_reg(CFG_SOURCE_WIDTH, 0);
    write_reg(CFG_SOURCE_HEIGHT, 0);
    write_reg(CFG_X_SCALE, 32767);
    write_reg(CFG_Y_SCALE, 0);
    push_drain();
    push_pixel(8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hAA, 8'h55, 8'h0F);
    wait_idle();
    flush_strip();

    // wide strip, then lower the width mid-drain so the position runs past the strip
    write_reg(CFG_TARGET_WIDTH, 4095);
    write_reg(CFG_SOURCE_WIDTH, 3);
    write_reg(CFG_SOURCE_HEIGHT, 1);
    write_reg(CFG_X_SCALE, 16384);
    write_reg(CFG_Y_SCALE, 16384);
    push_pixel(8'h00, 8'hFF, 8'h80);
    push_pixel(8'hFF, 8'h00, 8'h7F);
    push_pixel(8'h12, 8'h34, 8'h56);
    wait_idle();
    repeat (300) push_drain();
    wait_idle();
    repeat (20) @(posedge clk);
    write_reg(CFG_TARGET_WIDTH, 16);
    while (strip_ready) begin
      push_drain();
      wait_idle();
    end

    // overflow the column-zero accumulators with one long row
    write_reg(CFG_TARGET_WIDTH, 2);
    write_reg(CFG_SOURCE_WIDTH, 1040);
    write_reg(CFG_X_SCALE, 1);
    repeat (1040) push_pixel(8'hFF, 8'hFF, 8'hFF);
    wait_idle();
    flush_strip();

    // frame left open with a huge height, then closed with a smaller one
    write_reg(CFG_TARGET_WIDTH, 5);
    write_reg(CFG_SOURCE_WIDTH, 2);
    write_reg(CFG_SOURCE_HEIGHT, 32767);
    write_reg(CFG_X_SCALE, 16384);
    write_reg(CFG_Y_SCALE, 16384);
    run_rows(10, 1'b1);
    write_reg(CFG_SOURCE_HEIGHT, 12);
    run_rows(2, 1'b0);

    while (n_items < ITEM_GOAL) begin
      repeat (20) @(posedge clk);
      write_reg(CFG_TARGET_WIDTH, ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40)
                                                              : $urandom_range(1, 16));
      write_reg(CFG_SOURCE_WIDTH, $urandom_range(1, 10));
      write_reg(CFG_SOURCE_HEIGHT, $urandom_range(1, 12));
      write_reg(CFG_X_SCALE, rand_scale());
      write_reg(CFG_Y_SCALE, rand_scale());
      if ($urandom_range(0, 3) == 0) begin
        push_drain();
        wait_idle();
      end
      run_rows(clampu(sh_reg, 1, SRC_MAX) - src_row, $urandom_range(0, 2) == 0);
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/awd_pkg.sv
hdl/awd_norm.sv
hdl/area_weighted_image_downscaler.sv
verif/testbench.sv
